// File: hdl/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the centered moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

   // width of the half-width configuration word
   localparam int CFG_WIDTH = 5;

   // width of the saturating record sample counter
   localparam int SEEN_WIDTH = 16;

   // commands from the record controller to the window unit
   typedef struct packed {
      logic shift;   // a new sample entered the ring, window ages by one
      logic clear;   // record finished, window becomes empty
      logic start;   // move the window onto a new target
   } win_cmd_type;

endpackage

// File: hdl/centered_moving_average_top.sv
// ----------------------------------------------------------------------------
// centered_moving_average_top
// Centered boxcar smoother with windows that shrink toward both record ends.
// ----------------------------------------------------------------------------
// each input word is written to the ring and checked; a word that is
//   released then moves the window one ring access at a time (two accesses
//   in the steady state) and goes through the divider; a new input word is
//   taken only once the controller is idle again; ring reads share one port
// reset: synchronous, clears half_width, the record counters and the window;
//   ring contents are left as they are and are never read before written
module centered_moving_average_top #(
   parameter int MAX_HALF_WIDTH = 16,
   parameter int SAMPLE_WIDTH   = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample,
   input  logic                               req_last_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_smoothed,
   output logic                               rsp_last_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cma_pkg::CFG_WIDTH-1:0]      csr_half_width
);

   localparam int RING_DEPTH = 2 * MAX_HALF_WIDTH + 2;
   localparam int AW         = $clog2(RING_DEPTH);
   localparam int PW         = $clog2(MAX_HALF_WIDTH + 2);
   localparam int HBW        = $clog2(MAX_HALF_WIDTH + 1);
   localparam int SUMW       = SAMPLE_WIDTH + $clog2(2 * MAX_HALF_WIDTH + 2);
   localparam int SEENW      = cma_pkg::SEEN_WIDTH;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_WIN   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [HBW-1:0]                  hcfg_ff, hcfg_in;
   logic [SEENW-1:0]                seen_ff, seen_in;
   logic [PW-1:0]                   pend_ff, pend_in;
   logic [AW-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic                            flush_ff, flush_in;
   logic [HBW-1:0]                  h_ff, h_in;
   logic                            rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0]  rsp_smoothed_ff;
   logic                            rsp_last_ff;

   logic                            accept;
   logic                            emit;
   logic                            rsp_load;
   logic [PW-1:0]                   center;
   logic [SEENW-1:0]                left;
   logic [PW-1:0]                   hr;
   logic [HBW-1:0]                  h_sel;
   logic [AW-1:0]                   t_lo;
   logic [AW-1:0]                   t_hi;

   cma_pkg::win_cmd_type            win_cmd;
   logic                            win_done;
   logic signed [SUMW-1:0]          win_sum;
   logic                            rd_en;
   logic [AW-1:0]                   rd_addr;
   logic [SAMPLE_WIDTH-1:0]         rd_data;
   logic                            div_start;
   logic                            div_done;
   logic signed [SAMPLE_WIDTH-1:0]  div_q;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // config word saturates at the largest supported half-width
   always_comb begin
      hcfg_in = hcfg_ff;
      if (csr_valid) begin
         if (32'(csr_half_width) > MAX_HALF_WIDTH) begin
            hcfg_in = HBW'(MAX_HALF_WIDTH);
         end else begin
            hcfg_in = HBW'(csr_half_width);
         end
      end
   end

   // window of the oldest pending output: h = min(left, right, half_width)
   always_comb begin
      emit   = flush_ff ? (pend_ff != '0) : (pend_ff > PW'(hcfg_ff));
      center = pend_ff - 1'b1;
      left   = seen_ff - SEENW'(pend_ff);
      hr     = (left < SEENW'(center)) ? PW'(left) : center;
      h_sel  = (hr > PW'(hcfg_ff)) ? hcfg_ff : HBW'(hr);
      t_lo   = AW'(center) - AW'(h_sel);
      t_hi   = AW'(center) + AW'(h_sel);
   end

   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      pend_in   = pend_ff;
      wr_ptr_in = wr_ptr_ff;
      flush_in  = flush_ff;
      h_in      = h_ff;
      win_cmd   = '0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wr_ptr_in = (wr_ptr_ff == AW'(RING_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
               if (seen_ff != '1) begin
                  seen_in = seen_ff + 1'b1;
               end
               pend_in       = pend_ff + 1'b1;
               flush_in      = req_last_in;
               win_cmd.shift = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (emit) begin
               win_cmd.start = 1'b1;
               h_in          = h_sel;
               state_in      = ST_WIN;
            end else begin
               if (flush_ff) begin
                  seen_in       = '0;
                  flush_in      = 1'b0;
                  win_cmd.clear = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_WIN: begin
            if (win_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // output register free or emptying this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               pend_in  = pend_ff - 1'b1;
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hcfg_ff      <= '0;
         seen_ff      <= '0;
         pend_ff      <= '0;
         wr_ptr_ff    <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hcfg_ff   <= hcfg_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
         wr_ptr_ff <= wr_ptr_in;
         flush_ff  <= flush_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      if (rsp_load) begin
         rsp_smoothed_ff <= div_q;
         rsp_last_ff     <= flush_ff && (pend_ff == PW'(1));
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_smoothed = rsp_smoothed_ff;
   assign rsp_last_out = rsp_last_ff;

   cma_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cma_window #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .cmd     (win_cmd),
      .t_lo    (t_lo),
      .t_hi    (t_hi),
      .wr_ptr  (wr_ptr_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .done    (win_done),
      .sum     (win_sum)
   );

   cma_div #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (win_sum),
      .h     (h_ff),
      .done  (div_done),
      .quot  (div_q)
   );

endmodule

// File: hdl/cma_ram.sv
// ----------------------------------------------------------------------------
// cma_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cma_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 34
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cma_window.sv
// ----------------------------------------------------------------------------
// cma_window
// Running window sum over the sample ring. The window is kept as a pair of
// offsets back from the newest sample and moved onto a target one ring
// access at a time, adding entries that come in and subtracting entries
// that leave.
// ----------------------------------------------------------------------------
module cma_window #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int MAX_HALF_WIDTH = 16,
   localparam int RING_DEPTH    = 2 * MAX_HALF_WIDTH + 2,
   localparam int AW            = $clog2(RING_DEPTH),
   localparam int SUMW          = SAMPLE_WIDTH + $clog2(2 * MAX_HALF_WIDTH + 2)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cma_pkg::win_cmd_type          cmd,
   input  logic [AW-1:0]                 t_lo,
   input  logic [AW-1:0]                 t_hi,
   input  logic [AW-1:0]                 wr_ptr,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   input  logic [SAMPLE_WIDTH-1:0]       rd_data,
   output logic                          done,
   output logic signed [SUMW-1:0]        sum
);

   logic                   busy_ff, busy_in;
   logic                   empty_ff, empty_in;
   logic [AW-1:0]          lo_ff, lo_in;
   logic [AW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          t_lo_ff;
   logic [AW-1:0]          t_hi_ff;
   logic                   op_vld_ff;
   logic                   op_sub_ff;
   logic signed [SUMW-1:0] sum_ff, sum_in;

   logic                   issue;
   logic                   op_sub;
   logic [AW-1:0]          back;
   logic [AW:0]            addr_raw;
   logic signed [SUMW-1:0] ext;

   // pick the next ring access: grow toward the target first, then trim
   always_comb begin
      issue    = 1'b0;
      op_sub   = 1'b0;
      back     = lo_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      empty_in = empty_ff;
      busy_in  = busy_ff;
      if (busy_ff) begin
         if (empty_ff) begin
            issue    = 1'b1;
            back     = t_lo_ff;
            lo_in    = t_lo_ff;
            hi_in    = t_lo_ff;
            empty_in = 1'b0;
         end else if (t_lo_ff < lo_ff) begin
            issue = 1'b1;
            back  = lo_ff - 1'b1;
            lo_in = lo_ff - 1'b1;
         end else if (t_hi_ff > hi_ff) begin
            issue = 1'b1;
            back  = hi_ff + 1'b1;
            hi_in = hi_ff + 1'b1;
         end else if (lo_ff < t_lo_ff) begin
            issue  = 1'b1;
            op_sub = 1'b1;
            back   = lo_ff;
            lo_in  = lo_ff + 1'b1;
         end else if (hi_ff > t_hi_ff) begin
            issue  = 1'b1;
            op_sub = 1'b1;
            back   = hi_ff;
            hi_in  = hi_ff - 1'b1;
         end
         if (!issue && !op_vld_ff) begin
            busy_in = 1'b0;
         end
      end else begin
         if (cmd.shift && !empty_ff) begin
            lo_in = lo_ff + 1'b1;
            hi_in = hi_ff + 1'b1;
         end
         if (cmd.clear) begin
            empty_in = 1'b1;
         end
         if (cmd.start) begin
            busy_in = 1'b1;
         end
      end
   end

   // offset back from the newest sample to ring address
   always_comb begin
      addr_raw = {1'b0, wr_ptr} + (AW+1)'(RING_DEPTH - 1) - {1'b0, back};
      if (addr_raw >= (AW+1)'(RING_DEPTH)) begin
         rd_addr = AW'(addr_raw - (AW+1)'(RING_DEPTH));
      end else begin
         rd_addr = AW'(addr_raw);
      end
   end

   assign rd_en = issue;
   assign ext   = {{(SUMW-SAMPLE_WIDTH){rd_data[SAMPLE_WIDTH-1]}}, rd_data};

   always_comb begin
      sum_in = sum_ff;
      if (cmd.clear) begin
         sum_in = '0;
      end else if (op_vld_ff) begin
         if (op_sub_ff) begin
            sum_in = sum_ff - ext;
         end else begin
            sum_in = sum_ff + ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         empty_ff  <= 1'b1;
         op_vld_ff <= 1'b0;
         sum_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         empty_ff  <= empty_in;
         op_vld_ff <= issue;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      op_sub_ff <= op_sub;
      if (cmd.start) begin
         t_lo_ff <= t_lo;
         t_hi_ff <= t_hi;
      end
   end

   assign done = busy_ff && !issue && !op_vld_ff;
   assign sum  = sum_ff;

endmodule

// File: hdl/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// Rounded division of the window sum by the odd count 2h+1. The magnitude
// plus h is multiplied by a truncated reciprocal in two partial products,
// the estimate is at most one low and is fixed by one compare.
// ----------------------------------------------------------------------------
module cma_div #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int MAX_HALF_WIDTH = 16,
   localparam int HBW           = $clog2(MAX_HALF_WIDTH + 1),
   localparam int SUMW          = SAMPLE_WIDTH + $clog2(2 * MAX_HALF_WIDTH + 2)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [SUMW-1:0]         sum,
   input  logic [HBW-1:0]                 h,
   output logic                           done,
   output logic signed [SAMPLE_WIDTH-1:0] quot
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int CNTW = $clog2(2 * MAX_HALF_WIDTH + 2);
   localparam int NW   = SW - 1 + $clog2(2 * MAX_HALF_WIDTH + 1);
   localparam int K    = NW;
   localparam int RW   = K + 1;
   localparam int LOW  = (NW + 1) / 2;
   localparam int HIW  = NW - LOW;
   localparam int PRW  = NW + RW;
   localparam int DW   = NW + 1;

   typedef enum logic [4:0] {
      DV_IDLE = 5'b00001,
      DV_MLO  = 5'b00010,
      DV_MHI  = 5'b00100,
      DV_BACK = 5'b01000,
      DV_FIX  = 5'b10000
   } step_type;

   logic [RW-1:0] recip_tab [MAX_HALF_WIDTH+1];

   for (genvar gi = 0; gi <= MAX_HALF_WIDTH; gi++) begin : g_recip
      localparam logic [RW-1:0] RV = RW'((64'd1 << K) / (2 * gi + 1));
      assign recip_tab[gi] = RV;
   end

   step_type            step_ff, step_in;
   logic                done_ff;
   logic                neg_ff;
   logic [NW-1:0]       num_ff;
   logic [CNTW-1:0]     cnt_ff;
   logic [RW-1:0]       recip_ff;
   logic [LOW+RW-1:0]   plo_ff;
   logic [SW-1:0]       qest_ff;
   logic [SW+CNTW-1:0]  qc_ff;
   logic [SW-1:0]       quot_ff;

   logic [SUMW-1:0]     mag;
   logic [HIW+RW-1:0]   phi;
   logic [PRW-1:0]      prod;
   logic [DW-1:0]       rem;
   logic [SW-1:0]       qfix;

   assign mag  = sum[SUMW-1] ? -sum : sum;
   assign phi  = num_ff[NW-1:LOW] * recip_ff;
   assign prod = (PRW'(phi) << LOW) + PRW'(plo_ff);
   assign rem  = DW'(num_ff) - DW'(qc_ff);
   assign qfix = qest_ff + SW'(rem >= DW'(cnt_ff));

   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         DV_IDLE: if (start) step_in = DV_MLO;
         DV_MLO:  step_in = DV_MHI;
         DV_MHI:  step_in = DV_BACK;
         DV_BACK: step_in = DV_FIX;
         DV_FIX:  step_in = DV_IDLE;
         default: step_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= DV_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= (step_ff == DV_FIX);
      end
   end

   always_ff @(posedge clock) begin
      if (step_ff == DV_IDLE && start) begin
         neg_ff   <= sum[SUMW-1];
         num_ff   <= NW'(mag) + NW'(h);
         cnt_ff   <= (CNTW'(h) << 1) | CNTW'(1);
         recip_ff <= recip_tab[h];
      end
      if (step_ff == DV_MLO) begin
         plo_ff <= num_ff[LOW-1:0] * recip_ff;
      end
      if (step_ff == DV_MHI) begin
         qest_ff <= prod[K +: SW];
      end
      if (step_ff == DV_BACK) begin
         qc_ff <= qest_ff * cnt_ff;
      end
      if (step_ff == DV_FIX) begin
         quot_ff <= neg_ff ? -qfix : qfix;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: hdl/cma_check.sv
// ----------------------------------------------------------------------------
// cma_check
// Port level checks of the centered moving average block, bound to the top.
// ----------------------------------------------------------------------------
module cma_check #(
   parameter int SAMPLE_WIDTH = 24
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic signed [SAMPLE_WIDTH-1:0]     req_sample,
   input logic                               req_last_in,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0]     rsp_smoothed,
   input logic                               rsp_last_out
);

   // a stalled result word holds its payload
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smoothed) && $stable(rsp_last_out))
      else $error("result word changed while stalled");

   // a waiting input word holds its payload
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sample) && $stable(req_last_in))
      else $error("input word changed while waiting");

   // no result word is left over from before reset
   a_rsp_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one word at a time: input closes after every accepted word
   a_req_one : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accepted word");

   // a fresh result only appears while the controller is busy with a word
   a_rsp_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("result word appeared while input was open");

endmodule

bind centered_moving_average_top cma_check #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cma_check (.*);
